// File: hdl/dvf_pkg.sv
// dvf_pkg: shared types and constants for the detection vote filter
// used by the controller, datapath and top level

package dvf_pkg;

	localparam int XW = 11;
	localparam int RW = 8;
	localparam int TW = 32;
	localparam int ENTRY_W = 2 * XW + RW + TW;
	localparam int DIST_W = 24;
	localparam int KEEP_W = 5;
	localparam int Q4_W = 12;

	localparam logic [1:0] REG_MAX_AGE = 2'd0;
	localparam logic [1:0] REG_NEAR_DIST = 2'd1;
	localparam logic [1:0] REG_KEEP = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INSERT,
		ST_SCAN,
		ST_TRIM,
		ST_OUTER,
		ST_INNER,
		ST_LAST,
		ST_DIV,
		ST_OUT
	} dvf_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic insert;
		logic scan_step;
		logic trim;
		logic outer_start;
		logic inner_step;
		logic outer_end;
		logic div_start;
		logic div_step;
		logic out_load;
	} dvf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic inner_last;
		logic outer_last;
		logic empty;
		logic div_done;
	} dvf_stat_t;

endpackage

// File: hdl/dvf_ctrl.sv
// dvf_ctrl: sequencing state machine of the detection vote filter
// depends on dvf_pkg

module dvf_ctrl
	import dvf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_free,
	input  dvf_stat_t stat,
	output dvf_cmd_t  cmd
);

	dvf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) state_d = ST_TRIM;
			end
			ST_TRIM: begin
				cmd.trim = 1'b1;
				state_d = ST_OUTER;
			end
			ST_OUTER: begin
				if (stat.empty) state_d = ST_OUT;
				else begin
					cmd.outer_start = 1'b1;
					state_d = ST_INNER;
				end
			end
			ST_INNER: begin
				cmd.inner_step = 1'b1;
				if (stat.inner_last) state_d = ST_LAST;
			end
			ST_LAST: begin
				cmd.outer_end = 1'b1;
				if (stat.outer_last) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else state_d = ST_OUTER;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_OUT;
				else cmd.div_step = 1'b1;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: hdl/dvf_datapath.sv
// dvf_datapath: detection ring store, age scan, pairwise vote and divider
// depends on dvf_pkg

module dvf_datapath
	import dvf_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dvf_cmd_t            cmd,
	output dvf_stat_t           stat,
	input  logic [TW-1:0]       max_age,
	input  logic [DIST_W-1:0]   near_dist_sq,
	input  logic [KEEP_W-1:0]   keep_limit,
	input  logic                in_has,
	input  logic [XW-1:0]       in_x,
	input  logic [XW-1:0]       in_y,
	input  logic [RW-1:0]       in_r,
	input  logic [TW-1:0]       in_tick,
	output logic                res_found,
	output logic [XW-1:0]       res_x,
	output logic [XW-1:0]       res_y,
	output logic [Q4_W-1:0]     res_q4,
	output logic [KEEP_W-1:0]   res_cnt
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = RW + CW + 4;
	localparam int DW = $clog2(SW + 1);

	// store as separate register arrays (read by scan, pair and winner indexes)
	logic [XW-1:0] sx_q [DEPTH];
	logic [XW-1:0] sy_q [DEPTH];
	logic [RW-1:0] sr_q [DEPTH];
	logic [TW-1:0] st_q [DEPTH];

	logic [CW-1:0] count_q, n_q, i_q, j_q, best_q, best_cnt_q, cnt_q;
	logic [AW-1:0] oldest_q;
	logic          has_q;
	logic [XW-1:0] ix_q, iy_q;
	logic [RW-1:0] ir_q;
	logic [TW-1:0] tick_q;
	logic [SW-1:0] sum_q, best_sum_q, rem_q, quo_q;
	logic [DW-1:0] div_i_q;
	logic [CW-1:0] keep_cnt;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, k[AW-1:0]};
		if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	// scan read
	logic [AW-1:0] scan_slot, wr_slot, a_slot, b_slot;
	logic [TW-1:0] age;
	logic          keep_it;
	assign scan_slot = slot(oldest_q, i_q);
	assign wr_slot   = slot(oldest_q, n_q);
	assign age       = tick_q - st_q[scan_slot];
	assign keep_it   = age <= max_age;

	// pair distance, registered squares
	logic [XW-1:0] dx, dy;
	logic [2*XW-1:0] dx2_s1, dy2_s1;
	logic [RW-1:0] br_s1;
	logic          v_s1;
	logic [2*XW:0] d2;
	assign a_slot = slot(oldest_q, i_q);
	assign b_slot = slot(oldest_q, j_q);
	assign dx = (sx_q[a_slot] > sx_q[b_slot]) ? sx_q[a_slot] - sx_q[b_slot]
	                                          : sx_q[b_slot] - sx_q[a_slot];
	assign dy = (sy_q[a_slot] > sy_q[b_slot]) ? sy_q[a_slot] - sy_q[b_slot]
	                                          : sy_q[b_slot] - sy_q[a_slot];
	assign d2 = {1'b0, dx2_s1} + {1'b0, dy2_s1};

	logic [CW-1:0] lim;
	always_comb begin
		lim = (32'(keep_limit) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(keep_limit);
		keep_cnt = (n_q > lim) ? lim : n_q;
	end

	// sum of the winner, including a last entry that wins in the same cycle
	logic [SW-1:0] win_sum;
	assign win_sum = (cmd.outer_end && cnt_q > best_cnt_q) ? sum_q : best_sum_q;

	assign stat.scan_done  = (i_q + 1'b1 >= count_q) || (count_q == '0);
	assign stat.inner_last = (j_q == count_q);
	assign stat.outer_last = (i_q + 1'b1 == count_q);
	assign stat.empty      = (count_q == '0);
	assign stat.div_done   = (div_i_q == '0);

	logic [SW-1:0] rem_sh;
	assign rem_sh = {rem_q[SW-2:0], quo_q[SW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			has_q <= in_has; ix_q <= in_x; iy_q <= in_y; ir_q <= in_r; tick_q <= in_tick;
		end
		if (cmd.insert && has_q) begin
			sx_q[slot(oldest_q, (count_q >= CW'(DEPTH)) ? '0 : count_q)] <= ix_q;
			sy_q[slot(oldest_q, (count_q >= CW'(DEPTH)) ? '0 : count_q)] <= iy_q;
			sr_q[slot(oldest_q, (count_q >= CW'(DEPTH)) ? '0 : count_q)] <= ir_q;
			st_q[slot(oldest_q, (count_q >= CW'(DEPTH)) ? '0 : count_q)] <= tick_q;
		end
		// compaction in place: live entries move to ring positions 0..n-1
		if (cmd.scan_step && count_q != '0 && keep_it) begin
			sx_q[wr_slot] <= sx_q[scan_slot];
			sy_q[wr_slot] <= sy_q[scan_slot];
			sr_q[wr_slot] <= sr_q[scan_slot];
			st_q[wr_slot] <= st_q[scan_slot];
		end
		dx2_s1 <= (2*XW)'(dx) * (2*XW)'(dx);
		dy2_s1 <= (2*XW)'(dy) * (2*XW)'(dy);
		br_s1  <= sr_q[b_slot];
		v_s1   <= cmd.inner_step && (j_q < count_q);
		if (cmd.outer_start) begin
			sum_q <= '0; cnt_q <= '0;
		end else if (v_s1 && {2'b0, d2} <= {1'b0, near_dist_sq}) begin
			sum_q <= sum_q + SW'(br_s1);
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.div_start) begin
			rem_q <= '0; quo_q <= {win_sum[SW-5:0], 4'b0}; div_i_q <= DW'(SW);
		end else if (cmd.div_step) begin
			// one restoring step per cycle
			if (rem_sh >= SW'(best_cnt_q)) begin
				rem_q <= rem_sh - SW'(best_cnt_q);
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
			div_i_q <= div_i_q - 1'b1;
		end
		if (cmd.outer_end && cnt_q > best_cnt_q) begin
			best_cnt_q <= cnt_q; best_sum_q <= sum_q;
		end else if (cmd.trim) best_cnt_q <= '0;
		if (cmd.out_load) begin
			res_found <= !stat.empty;
			res_x   <= stat.empty ? '0 : sx_q[slot(oldest_q, best_q)];
			res_y   <= stat.empty ? '0 : sy_q[slot(oldest_q, best_q)];
			res_q4  <= stat.empty ? '0 : quo_q[Q4_W-1:0];
			res_cnt <= stat.empty ? '0 : KEEP_W'(best_cnt_q);
		end
	end

	// pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; oldest_q <= '0; n_q <= '0; i_q <= '0; j_q <= '0; best_q <= '0;
		end else begin
			if (cmd.insert) begin
				if (has_q) begin
					if (count_q >= CW'(DEPTH)) oldest_q <= slot(oldest_q, CW'(1));
					else count_q <= count_q + 1'b1;
				end
				i_q <= '0; n_q <= '0;
			end
			if (cmd.scan_step && count_q != '0) begin
				if (keep_it) n_q <= n_q + 1'b1;
				i_q <= i_q + 1'b1;
			end
			if (cmd.trim) begin
				// newest keep entries sit at n-keep..n-1 of the ring
				oldest_q <= slot(oldest_q, n_q - keep_cnt);
				count_q <= keep_cnt;
				i_q <= '0;
				best_q <= '0;
			end
			if (cmd.outer_start) j_q <= '0;
			else if (cmd.inner_step) j_q <= j_q + 1'b1;
			if (cmd.outer_end) begin
				i_q <= i_q + 1'b1;
				if (cnt_q > best_cnt_q) best_q <= i_q;
			end
		end
	end

endmodule

// File: hdl/detection_vote_filter.sv
// detection_vote_filter: top level, register file, stream ports
// depends on dvf_pkg, dvf_ctrl and dvf_datapath
//
// usage: one input transaction per camera frame on s_axis; each yields
// exactly one result transaction on m_axis.
// input tdata: has_detection, pos_x, pos_y, cand_radius, now_tick.
// output tdata: found, ball_x, ball_y, ball_radius_q4, support_count.
// registers: 0 max_age, 1 near_dist_sq, 2 keep_limit via cfg_we/cfg_index.
// the work is set by the single pairwise distance unit, which visits one
// pair per cycle over the N kept entries, then by a one-bit-per-cycle
// divider of width SW = 17.
// one item is processed at a time; s_axis_tready is high only when idle.
// the result sits in an output register; while the receiver stalls a
// new item may be accepted and processed, waiting before its output load.
// reset clears the store (count zero) and loads register defaults.

module detection_vote_filter
	import dvf_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // has_detection, pos_x, pos_y, cand_radius, now_tick
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // found, ball_x, ball_y, ball_radius_q4, support_count
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [TW-1:0] max_age_q;
	logic [DIST_W-1:0] near_q;
	logic [KEEP_W-1:0] keep_q;
	dvf_cmd_t cmd;
	dvf_stat_t stat;
	logic found;
	logic [XW-1:0] bx, by;
	logic [Q4_W-1:0] q4;
	logic [KEEP_W-1:0] cnt;
	logic out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= 32'd1000; near_q <= 24'd144; keep_q <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_AGE:   max_age_q <= cfg_data;
				REG_NEAR_DIST: near_q <= cfg_data[DIST_W-1:0];
				REG_KEEP:      keep_q <= cfg_data[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (cmd.out_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	assign m_axis_tdata = {cnt, q4, by, bx, found};

	dvf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_free(out_free), .stat(stat), .cmd(cmd)
	);

	dvf_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.max_age(max_age_q), .near_dist_sq(near_q), .keep_limit(keep_q),
		.in_has(s_axis_tdata[0]), .in_x(s_axis_tdata[11:1]), .in_y(s_axis_tdata[22:12]),
		.in_r(s_axis_tdata[30:23]), .in_tick(s_axis_tdata[62:31]),
		.res_found(found), .res_x(bx), .res_y(by), .res_q4(q4), .res_cnt(cnt)
	);

endmodule

// File: hdl/dvf_checker.sv
// dvf_checker: port-level assertions for detection_vote_filter
// bound to the top level; depends on nothing else

module dvf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// no input taken the cycle after one is taken
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("back to back accept");

	// not found means zero payload
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[39:1] == '0)
		else $error("payload without detection");

endmodule

bind detection_vote_filter dvf_checker u_chk (.*);
